FILE: sv/selm_pkg.sv
// ----------------------------------------------------------------------------
// selm_pkg: shared definitions for the shared/exclusive lock manager
// Field widths, command, state and outcome codes, the strobe struct passed
// from the sequencer to the slot table, and the result struct.
// ----------------------------------------------------------------------------
package selm_pkg;

	localparam int MAX_SLOTS_DEF = 32;
	localparam int CMD_W         = 3;
	localparam int ID_W          = 32;
	localparam int MU_W          = 6;
	localparam int HOLD_W        = 6;
	localparam int SIDX_W        = 5;
	localparam int S_TDATA_W     = 40;
	localparam int M_TDATA_W     = 16;

	localparam logic [MU_W-1:0]   MAX_USERS_RST = 6'd32;
	localparam logic [HOLD_W-1:0] HOLD_MAX      = 6'd63;

	typedef enum logic [CMD_W-1:0] {
		CMD_STATUS  = 3'd0,
		CMD_EXCL    = 3'd1,
		CMD_SHARED  = 3'd2,
		CMD_RELEASE = 3'd3,
		CMD_LOCK    = 3'd4,
		CMD_UNLOCK  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_FREE   = 2'd0,
		ST_EXCL   = 2'd1,
		ST_SHARED = 2'd2,
		ST_LOCKED = 2'd3
	} lock_state_t;

	typedef enum logic [1:0] {
		OC_OK     = 2'd0,
		OC_BUSY   = 2'd1,
		OC_NOSLOT = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_SCAN = 2'd1,
		FSM_DONE = 2'd2
	} fsm_state_t;

	// slot table strobes from the sequencer
	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} tbl_ctl_t;

	typedef struct packed {
		logic               slot_valid;
		logic [SIDX_W-1:0]  slot_index;
		logic [HOLD_W-1:0]  holder_count;
		lock_state_t        lock_state;
		outcome_t           outcome;
	} res_t;

endpackage

FILE: sv/shared_exclusive_lock_manager_top.sv
// Timing: status, exclusive, lock, unlock and refused requests are decided on acceptance
//   and go via the result register to the output register; if max_users > 1, shared
//   and release scan the table one slot per cycle, at most n = min(max_users, MAX_SLOTS).
// Throughput: one transaction in flight; the single slot-table read port and
//   comparator set the scan length. Input is taken again once the result is queued.
// Reset (arst_n low): lock free, no holders, owner 0, slot table empty, max_users 32.
// ----------------------------------------------------------------------------
// shared_exclusive_lock_manager_top: reader/writer lock with a slot table
// Stream request in, stream result out, one configuration register.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_manager_top #(
	parameter int MAX_SLOTS = selm_pkg::MAX_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [selm_pkg::MU_W-1:0]        cfg_wdata,     // max_users
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [selm_pkg::S_TDATA_W-1:0]   s_tdata,       // command[2:0], requester_id[34:3]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [selm_pkg::M_TDATA_W-1:0]   m_tdata        // outcome[1:0], lock_state[3:2],
	                                                        // holder_count[9:4],
	                                                        // slot_index[14:10], slot_valid[15]
);
	import selm_pkg::*;

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	logic [MU_W-1:0] max_users_q;
	tbl_ctl_t        tbl_ctl;
	logic [AW-1:0]   tbl_rd_addr;
	logic [AW-1:0]   tbl_wr_addr;
	logic [ID_W-1:0] tbl_wr_data;
	logic [ID_W-1:0] tbl_key;
	logic            tbl_hit;
	res_t            m_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_users_q <= MAX_USERS_RST;
		end else if (cfg_we) begin
			max_users_q <= cfg_wdata;
		end
	end

	selm_ctrl #(
		.SLOTS(MAX_SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_users   (max_users_q),
		.s_valid     (s_tvalid),
		.s_ready     (s_tready),
		.s_cmd       (cmd_t'(s_tdata[CMD_W-1:0])),
		.s_id        (s_tdata[CMD_W +: ID_W]),
		.m_valid     (m_tvalid),
		.m_ready     (m_tready),
		.m_res       (m_res),
		.tbl_ctl     (tbl_ctl),
		.tbl_rd_addr (tbl_rd_addr),
		.tbl_wr_addr (tbl_wr_addr),
		.tbl_wr_data (tbl_wr_data),
		.tbl_key     (tbl_key),
		.tbl_hit     (tbl_hit)
	);

	selm_slot_table #(
		.SLOTS(MAX_SLOTS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (tbl_rd_addr),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.key     (tbl_key),
		.hit     (tbl_hit)
	);

	assign m_tdata = m_res;

endmodule

FILE: sv/selm_slot_table.sv
// ----------------------------------------------------------------------------
// selm_slot_table: shared-user slot table with one compare unit
// Single-port-read memory of slot owners with per-entry valid bits; the
// registered read word is compared against the search key.
// ----------------------------------------------------------------------------
module selm_slot_table #(
	parameter int SLOTS = selm_pkg::MAX_SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  selm_pkg::tbl_ctl_t          ctl,
	input  logic [AW-1:0]               rd_addr,
	input  logic [AW-1:0]               wr_addr,
	input  logic [selm_pkg::ID_W-1:0]   wr_data,
	input  logic [selm_pkg::ID_W-1:0]   key,
	output logic                        hit
);
	import selm_pkg::*;

	logic [ID_W-1:0]  mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [ID_W-1:0]  rd_data_q;
	logic             rd_vld_q;
	logic [ID_W-1:0]  entry;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// entries never written since the last clear read as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.wr) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign entry = rd_vld_q ? rd_data_q : '0;
	assign hit   = (entry == key);

endmodule

FILE: sv/selm_ctrl.sv
// ----------------------------------------------------------------------------
// selm_ctrl: request sequencer and lock state
// Decides direct commands in the accept cycle, drives the slot scan for
// shared and release requests, and holds the result register.
// ----------------------------------------------------------------------------
module selm_ctrl #(
	parameter int SLOTS = selm_pkg::MAX_SLOTS_DEF,
	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [selm_pkg::MU_W-1:0]   max_users,
	input  logic                        s_valid,
	output logic                        s_ready,
	input  selm_pkg::cmd_t              s_cmd,
	input  logic [selm_pkg::ID_W-1:0]   s_id,
	output logic                        m_valid,
	input  logic                        m_ready,
	output selm_pkg::res_t              m_res,
	output selm_pkg::tbl_ctl_t          tbl_ctl,
	output logic [AW-1:0]               tbl_rd_addr,
	output logic [AW-1:0]               tbl_wr_addr,
	output logic [selm_pkg::ID_W-1:0]   tbl_wr_data,
	output logic [selm_pkg::ID_W-1:0]   tbl_key,
	input  logic                        tbl_hit
);
	import selm_pkg::*;

	fsm_state_t        state_q, state_d;
	lock_state_t       lock_q, lock_d;
	logic [HOLD_W-1:0] holders_q, holders_d;
	logic [ID_W-1:0]   owner_q, owner_d;
	cmd_t              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [CW-1:0]     n_q, n_calc;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     cmp_idx_s1;
	logic              cmp_vld_s1;
	res_t              res_q, res_d;
	res_t              m_res_q;
	logic              m_valid_q;

	logic accept, single, scan_start, scan_rd;
	logic hit_now, last_now, scan_end, res_load, out_free;

	assign accept   = s_valid && s_ready;
	assign single   = (max_users <= MU_W'(1));
	assign scan_rd  = (state_q == FSM_SCAN) && (rd_idx_q < n_q);
	assign hit_now  = (state_q == FSM_SCAN) && cmp_vld_s1 && tbl_hit;
	assign last_now = (state_q == FSM_SCAN) && cmp_vld_s1 && (cmp_idx_s1 == n_q - CW'(1));
	assign scan_end = hit_now || last_now;
	assign out_free = !m_valid_q || m_ready;

	always_comb begin
		scan_start = 1'b0;
		if (accept && !single) begin
			if (s_cmd == CMD_RELEASE) begin
				scan_start = 1'b1;
			end else if (s_cmd == CMD_SHARED &&
					(lock_q == ST_FREE || lock_q == ST_SHARED)) begin
				scan_start = 1'b1;
			end
		end
	end

	always_comb begin
		if (int'(max_users) < SLOTS) begin
			n_calc = CW'(max_users);
		end else begin
			n_calc = CW'(SLOTS);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = scan_start ? FSM_SCAN : FSM_DONE;
				end
			end
			FSM_SCAN: begin
				if (scan_end) begin
					state_d = FSM_DONE;
				end
			end
			FSM_DONE: begin
				if (out_free) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_ready     = (state_q == FSM_IDLE);
		tbl_ctl.rd  = scan_rd;
		tbl_ctl.wr  = hit_now;
		tbl_ctl.clr = 1'b0;
		if (accept && !single) begin
			case (s_cmd)
				CMD_EXCL: tbl_ctl.clr = (lock_q == ST_FREE) ||
					(lock_q == ST_LOCKED && owner_q == s_id);
				CMD_LOCK:   tbl_ctl.clr = (lock_q == ST_FREE);
				CMD_UNLOCK: tbl_ctl.clr = (lock_q == ST_LOCKED);
				default:    tbl_ctl.clr = 1'b0;
			endcase
		end
		tbl_rd_addr = rd_idx_q[AW-1:0];
		tbl_wr_addr = cmp_idx_s1[AW-1:0];
		tbl_wr_data = (cmd_q == CMD_SHARED) ? id_q : '0;
		tbl_key     = (cmd_q == CMD_SHARED) ? '0 : id_q;
	end

	// lock state update and result
	always_comb begin
		lock_d    = lock_q;
		holders_d = holders_q;
		owner_d   = owner_q;
		res_load  = 1'b0;
		res_d.outcome = OC_OK;
		res_d.slot_index = '0;
		res_d.slot_valid = 1'b0;
		if (accept) begin
			res_load = !scan_start;
			if (single) begin
				lock_d = ST_LOCKED;
			end else begin
				case (s_cmd)
					CMD_EXCL: begin
						if (tbl_ctl.clr) begin
							lock_d    = (lock_q == ST_LOCKED) ? ST_LOCKED : ST_EXCL;
							holders_d = HOLD_W'(1);
							owner_d   = s_id;
						end else begin
							res_d.outcome = OC_BUSY;
						end
					end
					CMD_SHARED: begin
						if (!scan_start) begin
							res_d.outcome = OC_BUSY;
						end
					end
					CMD_LOCK: begin
						if (lock_q == ST_FREE) begin
							lock_d    = ST_LOCKED;
							holders_d = HOLD_W'(1);
							owner_d   = s_id;
						end else begin
							res_d.outcome = OC_BUSY;
						end
					end
					CMD_UNLOCK: begin
						if (lock_q == ST_LOCKED) begin
							lock_d    = ST_FREE;
							holders_d = '0;
							owner_d   = '0;
						end
					end
					default: ;
				endcase
			end
		end else if (scan_end) begin
			res_load = 1'b1;
			if (cmd_q == CMD_SHARED) begin
				if (hit_now) begin
					lock_d = ST_SHARED;
					if (holders_q < HOLD_MAX) begin
						holders_d = holders_q + HOLD_W'(1);
					end
					res_d.slot_index = SIDX_W'(cmp_idx_s1);
					res_d.slot_valid = 1'b1;
				end else begin
					res_d.outcome = OC_NOSLOT;
				end
			end else begin
				if (holders_q > HOLD_W'(1)) begin
					holders_d = holders_q - HOLD_W'(1);
				end else if (lock_q != ST_LOCKED) begin
					lock_d    = ST_FREE;
					holders_d = '0;
					owner_d   = '0;
				end
			end
		end
		res_d.lock_state   = lock_d;
		res_d.holder_count = holders_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			lock_q     <= ST_FREE;
			holders_q  <= '0;
			owner_q    <= '0;
			cmp_vld_s1 <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			lock_q    <= lock_d;
			holders_q <= holders_d;
			owner_q   <= owner_d;
			if (scan_start) begin
				cmp_vld_s1 <= 1'b0;
			end else begin
				cmp_vld_s1 <= scan_rd;
			end
			if (state_q == FSM_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_cmd;
			id_q  <= s_id;
			n_q   <= n_calc;
		end
		if (scan_start) begin
			rd_idx_q <= '0;
		end else if (scan_rd) begin
			rd_idx_q <= rd_idx_q + CW'(1);
		end
		cmp_idx_s1 <= rd_idx_q;
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == FSM_DONE && out_free) begin
			m_res_q <= res_q;
		end
	end

	assign m_valid = m_valid_q;
	assign m_res   = m_res_q;

`ifndef ASSERT_OFF
	a_free_no_holders: assert property (@(posedge clk) disable iff (!arst_n)
		(lock_q == ST_FREE) |-> (holders_q == '0))
		else $error("free lock with nonzero holder count");

	a_excl_one_holder: assert property (@(posedge clk) disable iff (!arst_n)
		(lock_q == ST_EXCL) |-> (holders_q == HOLD_W'(1)))
		else $error("exclusive lock without exactly one holder");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_SCAN) |-> (rd_idx_q <= n_q))
		else $error("slot scan ran past the slots in use");

	a_grant_shared: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid && m_res.slot_valid) |->
			(m_res.lock_state == ST_SHARED && m_res.outcome == OC_OK))
		else $error("slot granted outside shared state");

	a_tbl_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_SCAN) |-> (!tbl_ctl.rd && !tbl_ctl.wr))
		else $error("slot table access outside a scan");
`endif

endmodule
